// ===== sv/rfa_pkg.sv =====
`timescale 1ns / 1ps

package rfa_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int RES_NUM_WIDTH     = 33;
  localparam int RES_DEN_WIDTH     = 31;
  localparam int OP_WIDTH          = 3;
  localparam int QUEUE_DEPTH       = 2;

  // operand slots
  localparam int IDX_AN = 0;
  localparam int IDX_AD = 1;
  localparam int IDX_BN = 2;
  localparam int IDX_BD = 3;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_INT = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    K_ZERO,   // unused opcode: 0 / 1
    K_ERR,    // bad operand: 0 / 0, flag set
    K_INT,
    K_ADD,
    K_SUB,
    K_MUL,
    K_DIV
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] neg;
  } rfa_cls_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_REDUCE,
    ST_GCD,
    ST_INTDIV,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// ===== sv/rfa_front.sv =====
`timescale 1ns / 1ps

module rfa_front #(
  parameter int OPERAND_WIDTH = rfa_pkg::OPERAND_WIDTH_DEF
) (
  input  logic [rfa_pkg::OP_WIDTH-1:0]      op,
  input  logic [3:0][OPERAND_WIDTH-1:0]     raw,
  output rfa_pkg::rfa_cls_t                 cls,
  output logic [3:0][OPERAND_WIDTH-1:0]     mag
);

  logic [3:0]     is_zero;
  logic           bad;
  logic [3:0]     neg;
  rfa_pkg::kind_t kind;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      neg[i]     = raw[i][OPERAND_WIDTH-1];
      // most negative value maps onto 2^(W-1), which still fits W unsigned bits
      mag[i]     = neg[i] ? (~raw[i] + OPERAND_WIDTH'(1)) : raw[i];
      is_zero[i] = (raw[i] == '0);
    end
  end

  assign bad = is_zero[rfa_pkg::IDX_AD] || is_zero[rfa_pkg::IDX_BD] ||
               ((op == rfa_pkg::OP_DIV) && is_zero[rfa_pkg::IDX_BN]);

  always_comb begin
    unique case (op)
      rfa_pkg::OP_ADD: kind = bad ? rfa_pkg::K_ERR : rfa_pkg::K_ADD;
      rfa_pkg::OP_SUB: kind = bad ? rfa_pkg::K_ERR : rfa_pkg::K_SUB;
      rfa_pkg::OP_MUL: kind = bad ? rfa_pkg::K_ERR : rfa_pkg::K_MUL;
      rfa_pkg::OP_DIV: kind = bad ? rfa_pkg::K_ERR : rfa_pkg::K_DIV;
      rfa_pkg::OP_INT: kind = is_zero[rfa_pkg::IDX_AD] ? rfa_pkg::K_ERR : rfa_pkg::K_INT;
      default:         kind = rfa_pkg::K_ZERO;
    endcase
  end

  assign cls = {kind, neg};

endmodule

// ===== sv/rfa_queue.sv =====
`timescale 1ns / 1ps

module rfa_queue #(
  parameter int DATA_WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [DATA_WIDTH-1:0] push_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  avail,
  output logic [DATA_WIDTH-1:0] pop_data
);

  localparam int Depth = rfa_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  logic [DATA_WIDTH-1:0] mem [Depth];
  logic [PtrW-1:0]       wr_ptr;
  logic [PtrW-1:0]       rd_ptr;
  logic [CntW-1:0]       count;

  assign full     = (count == CntW'(Depth));
  assign avail    = (count != '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// ===== sv/rfa_div.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module rfa_div #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          run;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial    = {rem, quo[DW-1]};
  assign diff     = trial - {1'b0, dvs};
  assign ge       = (trial >= {1'b0, dvs});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (run) begin
      quo <= {quo[DW-2:0], ge};
      rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(DW);
      end else if (run) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/rfa_back.sv =====
`timescale 1ns / 1ps

module rfa_back #(
  parameter int OPERAND_WIDTH = rfa_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_avail,
  input  rfa_pkg::rfa_cls_t                      q_cls,
  input  logic [3:0][OPERAND_WIDTH-1:0]          q_mag,
  output logic                                   q_pop,
  output logic                                   res_valid,
  input  logic                                   res_ready,
  output logic [rfa_pkg::RES_NUM_WIDTH-1:0]      res_num,
  output logic [rfa_pkg::RES_DEN_WIDTH-1:0]      res_den,
  output logic                                   bad_operand
);

  localparam int W    = OPERAND_WIDTH;
  localparam int PW   = 2 * W;
  localparam int KW   = $clog2(PW);
  localparam int ExtW = (PW > rfa_pkg::RES_NUM_WIDTH) ? PW : rfa_pkg::RES_NUM_WIDTH;

  rfa_pkg::state_t state, state_next;

  rfa_pkg::kind_t       kind;
  logic [3:0]           neg;
  logic [3:0][W-1:0]    mag;
  logic [PW-1:0]        prod;
  logic [PW-1:0]        t1;
  logic                 p1neg;
  logic                 p2neg;
  logic [PW-1:0]        nmag;
  logic [PW-1:0]        dmag;
  logic                 nneg;
  logic                 dneg;
  logic [PW-1:0]        gx;
  logic [PW-1:0]        gy;
  logic [KW-1:0]        k;
  logic [rfa_pkg::RES_NUM_WIDTH-1:0] onum;
  logic [rfa_pkg::RES_DEN_WIDTH-1:0] oden;
  logic                 obad;

  logic                 is_mul;
  logic                 is_sub;
  logic                 is_addsub;
  logic [W-1:0]         mx;
  logic [W-1:0]         my;
  logic [PW-1:0]        pm;
  logic                 s1;
  logic                 s2;
  logic [PW-1:0]        sum_mag;
  logic                 sum_neg;
  logic [PW-1:0]        g;
  logic                 gcd_eq;
  logic                 start_a;
  logic                 start_b;
  logic [PW-1:0]        a_dividend;
  logic [PW-1:0]        a_divisor;
  logic                 a_done;
  logic                 b_done;
  logic [PW-1:0]        qa;
  logic [PW-1:0]        qb;

  function automatic logic [rfa_pkg::RES_NUM_WIDTH-1:0] signed_out(input logic sgn,
                                                                   input logic [PW-1:0] m);
    logic [ExtW-1:0] e;
    e = ExtW'(m);
    if (sgn) begin
      e = ~e + ExtW'(1);
    end
    return e[rfa_pkg::RES_NUM_WIDTH-1:0];
  endfunction

  function automatic logic [rfa_pkg::RES_DEN_WIDTH-1:0] den_out(input logic [PW-1:0] m);
    logic [ExtW-1:0] e;
    e = ExtW'(m);
    return e[rfa_pkg::RES_DEN_WIDTH-1:0];
  endfunction

  assign is_mul    = (kind == rfa_pkg::K_MUL);
  assign is_sub    = (kind == rfa_pkg::K_SUB);
  assign is_addsub = (kind == rfa_pkg::K_ADD) || is_sub;

  // multiplier operands: first an*(bn|bd), then ad*(bd|bn), then ad*bd for add/sub
  always_comb begin
    mx = mag[rfa_pkg::IDX_AD];
    my = mag[rfa_pkg::IDX_BD];
    if (state == rfa_pkg::ST_MUL1) begin
      mx = mag[rfa_pkg::IDX_AN];
      my = is_mul ? mag[rfa_pkg::IDX_BN] : mag[rfa_pkg::IDX_BD];
    end else if (state == rfa_pkg::ST_MUL2) begin
      my = is_mul ? mag[rfa_pkg::IDX_BD] : mag[rfa_pkg::IDX_BN];
    end
  end

  assign pm = PW'(mx) * PW'(my);
  assign s1 = neg[rfa_pkg::IDX_AN] ^ (is_mul ? neg[rfa_pkg::IDX_BN] : neg[rfa_pkg::IDX_BD]);
  assign s2 = neg[rfa_pkg::IDX_AD] ^ (is_mul ? neg[rfa_pkg::IDX_BD] : neg[rfa_pkg::IDX_BN])
              ^ is_sub;

  // signed-magnitude add of t1 and the second product
  always_comb begin
    if (p1neg == p2neg) begin
      sum_mag = t1 + prod;
      sum_neg = p1neg;
    end else if (t1 >= prod) begin
      sum_mag = t1 - prod;
      sum_neg = p1neg;
    end else begin
      sum_mag = prod - t1;
      sum_neg = p2neg;
    end
  end

  assign gcd_eq = (gx == gy);
  assign g      = gx << k;

  assign a_dividend = (kind == rfa_pkg::K_INT) ? PW'(mag[rfa_pkg::IDX_AN]) : nmag;
  assign a_divisor  = (kind == rfa_pkg::K_INT) ? PW'(mag[rfa_pkg::IDX_AD]) : g;

  rfa_div #(.DW(PW)) u_div_num (
    .clk      (clk),
    .rst      (rst),
    .start    (start_a),
    .dividend (a_dividend),
    .divisor  (a_divisor),
    .done     (a_done),
    .quotient (qa)
  );

  rfa_div #(.DW(PW)) u_div_den (
    .clk      (clk),
    .rst      (rst),
    .start    (start_b),
    .dividend (dmag),
    .divisor  (g),
    .done     (b_done),
    .quotient (qb)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      rfa_pkg::ST_IDLE: begin
        if (q_avail) begin
          if (q_cls.kind == rfa_pkg::K_ZERO || q_cls.kind == rfa_pkg::K_ERR) begin
            state_next = rfa_pkg::ST_OUT;
          end else if (q_cls.kind == rfa_pkg::K_INT) begin
            state_next = rfa_pkg::ST_INTDIV;
          end else begin
            state_next = rfa_pkg::ST_MUL1;
          end
        end
      end
      rfa_pkg::ST_MUL1:   state_next = rfa_pkg::ST_MUL2;
      rfa_pkg::ST_MUL2:   state_next = rfa_pkg::ST_MUL3;
      rfa_pkg::ST_MUL3:   state_next = is_addsub ? rfa_pkg::ST_MUL4 : rfa_pkg::ST_REDUCE;
      rfa_pkg::ST_MUL4:   state_next = rfa_pkg::ST_REDUCE;
      rfa_pkg::ST_REDUCE: state_next = (nmag == '0) ? rfa_pkg::ST_OUT : rfa_pkg::ST_GCD;
      rfa_pkg::ST_GCD:    state_next = gcd_eq ? rfa_pkg::ST_DIV : rfa_pkg::ST_GCD;
      rfa_pkg::ST_INTDIV: state_next = rfa_pkg::ST_DIV;
      rfa_pkg::ST_DIV:    state_next = a_done ? rfa_pkg::ST_OUT : rfa_pkg::ST_DIV;
      rfa_pkg::ST_OUT:    state_next = res_ready ? rfa_pkg::ST_IDLE : rfa_pkg::ST_OUT;
      default:            state_next = rfa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    start_a   = 1'b0;
    start_b   = 1'b0;
    res_valid = 1'b0;
    unique case (state)
      rfa_pkg::ST_IDLE:   q_pop = q_avail;
      rfa_pkg::ST_GCD: begin
        start_a = gcd_eq;
        start_b = gcd_eq;
      end
      rfa_pkg::ST_INTDIV: start_a = 1'b1;
      rfa_pkg::ST_OUT:    res_valid = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rfa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rfa_pkg::ST_IDLE: begin
        if (q_avail) begin
          kind <= q_cls.kind;
          neg  <= q_cls.neg;
          mag  <= q_mag;
          onum <= '0;
          oden <= (q_cls.kind == rfa_pkg::K_ERR) ? '0 : rfa_pkg::RES_DEN_WIDTH'(1);
          obad <= (q_cls.kind == rfa_pkg::K_ERR);
        end
      end
      rfa_pkg::ST_MUL1: begin
        prod  <= pm;
        p1neg <= s1;
      end
      rfa_pkg::ST_MUL2: begin
        t1    <= prod;
        prod  <= pm;
        p2neg <= s2;
      end
      rfa_pkg::ST_MUL3: begin
        if (is_addsub) begin
          nmag <= sum_mag;
          nneg <= sum_neg;
          dneg <= neg[rfa_pkg::IDX_AD] ^ neg[rfa_pkg::IDX_BD];
          prod <= pm;
        end else begin
          nmag <= t1;
          nneg <= p1neg;
          dmag <= prod;
          dneg <= p2neg;
        end
      end
      rfa_pkg::ST_MUL4: dmag <= prod;
      rfa_pkg::ST_REDUCE: begin
        gx   <= nmag;
        gy   <= dmag;
        k    <= '0;
        onum <= '0;
        oden <= rfa_pkg::RES_DEN_WIDTH'(1);
        obad <= 1'b0;
      end
      rfa_pkg::ST_GCD: begin
        // binary gcd: strip shared twos into k, then odd-odd subtract-and-halve
        if (!gcd_eq) begin
          if (!gx[0] && !gy[0]) begin
            gx <= gx >> 1;
            gy <= gy >> 1;
            k  <= k + KW'(1);
          end else if (!gx[0]) begin
            gx <= gx >> 1;
          end else if (!gy[0]) begin
            gy <= gy >> 1;
          end else if (gx > gy) begin
            gx <= (gx - gy) >> 1;
          end else begin
            gy <= (gy - gx) >> 1;
          end
        end
      end
      rfa_pkg::ST_DIV: begin
        if (a_done) begin
          obad <= 1'b0;
          if (kind == rfa_pkg::K_INT) begin
            onum <= signed_out((neg[rfa_pkg::IDX_AN] ^ neg[rfa_pkg::IDX_AD]) && (qa != '0), qa);
            oden <= rfa_pkg::RES_DEN_WIDTH'(1);
          end else begin
            onum <= signed_out(nneg ^ dneg, qa);
            oden <= den_out(qb);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign res_num     = onum;
  assign res_den     = oden;
  assign bad_operand = obad;

  a_err_zero : assert property (@(posedge clk) disable iff (rst)
    res_valid && bad_operand |-> (res_num == '0) && (res_den == '0))
    else $error("error result carries nonzero fields");

  a_den_nz : assert property (@(posedge clk) disable iff (rst)
    res_valid && !bad_operand |-> (res_den != '0))
    else $error("zero denominator on a good result");

  a_gcd_nz : assert property (@(posedge clk) disable iff (rst)
    (state == rfa_pkg::ST_GCD) |-> (gx != '0) && (gy != '0))
    else $error("gcd operand went to zero");

  a_div_sync : assert property (@(posedge clk) disable iff (rst)
    (state == rfa_pkg::ST_DIV) && (kind != rfa_pkg::K_INT) |-> (a_done == b_done))
    else $error("numerator and denominator dividers out of step");

  a_pop_leaves_idle : assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state != rfa_pkg::ST_IDLE))
    else $error("popped item not taken up");

endmodule

// ===== sv/rational_fraction_alu.sv =====
`timescale 1ns / 1ps

// Rational ALU: adds, subtracts, multiplies or divides a = a_num/a_den and
// b = b_num/b_den (s_tuser selects the operation), or returns the truncated
// integer part of a, and delivers the result in lowest terms with a positive
// denominator. A zero a_den, a zero b_den (but for the integer part) or a
// zero divisor numerator sets bad_operand with a 0/0 result. The front
// classifies beats into a two-entry queue, so input is taken while the back
// is busy or a result is waiting, until the queue is full. The back works
// one item at a time: unused opcodes and errors go straight to the output
// state; the integer part runs one restoring divider; fractions pass through
// the shared W x W multiplier, binary GCD, then the two restoring dividers
// that divide out the GCD, and the output state (W = OPERAND_WIDTH; a zero
// numerator skips the GCD and dividers). A stalled result holds the back in
// its output state.
module rational_fraction_alu #(
  parameter int OPERAND_WIDTH = rfa_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // a_num, a_den, b_num, b_den (low to high), zero padded
  input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]   s_tdata,
  // req_type
  input  logic [rfa_pkg::OP_WIDTH-1:0]           s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // res_num, res_den, bad_operand (low to high), zero padded
  output logic [71:0]                            m_tdata
);

  localparam int W  = OPERAND_WIDTH;
  localparam int QW = $bits(rfa_pkg::rfa_cls_t) + 4 * W;

  logic [3:0][W-1:0]                 raw;
  rfa_pkg::rfa_cls_t                 f_cls;
  logic [3:0][W-1:0]                 f_mag;
  logic                              q_full;
  logic                              q_avail;
  logic                              q_pop;
  logic [QW-1:0]                     q_data;
  rfa_pkg::rfa_cls_t                 b_cls;
  logic [3:0][W-1:0]                 b_mag;
  logic [rfa_pkg::RES_NUM_WIDTH-1:0] res_num;
  logic [rfa_pkg::RES_DEN_WIDTH-1:0] res_den;
  logic                              bad_operand;

  assign raw      = s_tdata[4*W-1:0];
  assign s_tready = !q_full;

  rfa_front #(.OPERAND_WIDTH(W)) u_front (
    .op  (s_tuser),
    .raw (raw),
    .cls (f_cls),
    .mag (f_mag)
  );

  rfa_queue #(.DATA_WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid && !q_full),
    .push_data ({f_mag, f_cls}),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_data  (q_data)
  );

  assign {b_mag, b_cls} = q_data;

  rfa_back #(.OPERAND_WIDTH(W)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_avail     (q_avail),
    .q_cls       (b_cls),
    .q_mag       (b_mag),
    .q_pop       (q_pop),
    .res_valid   (m_tvalid),
    .res_ready   (m_tready),
    .res_num     (res_num),
    .res_den     (res_den),
    .bad_operand (bad_operand)
  );

  assign m_tdata = {7'd0, bad_operand, res_den, res_num};

endmodule
